### rtl/unsigned_to_decimal_ascii_defines.svh
// assertion macros for the decimal ascii converter rtl
// no dependencies
`ifndef UNSIGNED_TO_DECIMAL_ASCII_DEFINES_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication
`define U2DA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("u2da check failed");

// next-cycle implication
`define U2DA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("u2da check failed");

`endif

### rtl/u2da_pkg.sv
// constants, types and helpers for the decimal ascii converter
// no dependencies
package u2da_pkg;
  localparam int VALUE_BITS      = 64;
  localparam int STEPS_PER_STAGE = 8;
  localparam int NUM_STAGES      = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int SHIFT_BITS      = NUM_STAGES * STEPS_PER_STAGE;
  localparam int DIGITS          = 20;
  localparam int BCD_BITS        = DIGITS * 4;
  localparam int IDX_BITS        = $clog2(DIGITS);
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  typedef logic [BCD_BITS-1:0]   bcd_t;
  typedef logic [SHIFT_BITS-1:0] shift_t;
  typedef logic [IDX_BITS-1:0]   idx_t;

  function automatic idx_t msd_index(input bcd_t b);
    idx_t r;
    r = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (b[i*4 +: 4] != 4'd0) r = IDX_BITS'(i);
    end
    return r;
  endfunction
endpackage

### rtl/u2da_dabble_stage.sv
// one registered stage of shift-and-add-3 binary to bcd conversion
// depends on u2da_pkg
module u2da_dabble_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  u2da_pkg::shift_t in_shift,
  input  u2da_pkg::bcd_t   in_bcd,
  output logic             out_valid,
  input  logic             out_ready,
  output u2da_pkg::shift_t out_shift,
  output u2da_pkg::bcd_t   out_bcd
);
  import u2da_pkg::*;

  logic   valid_r;
  shift_t shift_r, shift_nxt;
  bcd_t   bcd_r, bcd_nxt;

  always_comb begin
    shift_nxt = in_shift;
    bcd_nxt   = in_bcd;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd_nxt[d*4 +: 4] >= 4'd5) bcd_nxt[d*4 +: 4] = bcd_nxt[d*4 +: 4] + 4'd3;
      end
      bcd_nxt   = {bcd_nxt[BCD_BITS-2:0], shift_nxt[SHIFT_BITS-1]};
      shift_nxt = {shift_nxt[SHIFT_BITS-2:0], 1'b0};
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      shift_r <= shift_nxt;
      bcd_r   <= bcd_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_shift = shift_r;
  assign out_bcd   = bcd_r;
endmodule

### rtl/u2da_serial.sv
// emits bcd digits as ascii, most significant nonzero digit first
// depends on u2da_pkg and the assertion macro header
`include "unsigned_to_decimal_ascii_defines.svh"
module u2da_serial (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  u2da_pkg::bcd_t in_bcd,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,  // [5:0] digit_char, rest zero
  output logic           out_tlast
);
  import u2da_pkg::*;

  logic busy_r;
  bcd_t bcd_r;
  idx_t idx_r;
  logic [3:0] digit;

  assign in_ready = !busy_r || (out_tready && idx_r == '0);
  assign digit    = bcd_r[idx_r*4 +: 4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (in_ready) begin
      busy_r <= in_valid;
      if (in_valid) begin
        idx_r <= msd_index(in_bcd);
      end
    end else if (out_tready) begin
      idx_r <= idx_r - 1'b1;
    end
    if (in_ready && in_valid) begin
      bcd_r <= in_bcd;
    end
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {2'b00, ASCII_ZERO + {2'b00, digit}};
  assign out_tlast  = idx_r == '0;

  `U2DA_ASSERT_NOW(a_idx_range, clk, rst_n, busy_r, idx_r <= IDX_BITS'(DIGITS - 1))
  `U2DA_ASSERT_NEXT(a_stall_hold, clk, rst_n, busy_r && !out_tready, busy_r && $stable(idx_r))
  `U2DA_ASSERT_NEXT(a_count_down, clk, rst_n, busy_r && out_tready && idx_r != '0, busy_r && idx_r == $past(idx_r) - 1'b1)
endmodule

### rtl/unsigned_to_decimal_ascii.sv
// Converts each 64-bit unsigned value to decimal ASCII digits, most significant first,
// no leading zeros, zero giving a single '0'; tlast marks the final digit. A value has
// 1 to 20 digits, sent one digit per cycle while out_tready is high by the digit
// serializer, which takes a new value in the cycle the previous value's last digit
// leaves; the conversion pipeline of 8 shift-and-add-3 stages buffers values ahead of it.
// depends on u2da_pkg, u2da_dabble_stage and u2da_serial
module unsigned_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] digit_char, [7:6] zero
  output logic        out_tlast
);
  import u2da_pkg::*;

  logic   vld [NUM_STAGES+1];
  logic   rdy [NUM_STAGES+1];
  shift_t shf [NUM_STAGES+1];
  bcd_t   bcd [NUM_STAGES+1];

  assign vld[0]    = in_tvalid;
  assign in_tready = rdy[0];
  assign shf[0]    = SHIFT_BITS'(in_tdata[VALUE_BITS-1:0]);
  assign bcd[0]    = '0;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    u2da_dabble_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[g]),
      .in_ready  (rdy[g]),
      .in_shift  (shf[g]),
      .in_bcd    (bcd[g]),
      .out_valid (vld[g+1]),
      .out_ready (rdy[g+1]),
      .out_shift (shf[g+1]),
      .out_bcd   (bcd[g+1])
    );
  end

  u2da_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (vld[NUM_STAGES]),
    .in_ready   (rdy[NUM_STAGES]),
    .in_bcd     (bcd[NUM_STAGES]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );
endmodule

### test/tb_unsigned_to_decimal_ascii.sv
// self-checking testbench for the 64-bit unsigned to decimal ascii converter
// depends on unsigned_to_decimal_ascii and u2da_pkg
module tb_unsigned_to_decimal_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0] digit_char;
    logic       last;
  } digit_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  digit_t      pending_digits[$];
  int          mismatches;
  int unsigned cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off;

  localparam int unsigned CYCLE_LIMIT = 400000;

  unsigned_to_decimal_ascii dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // decimal digits of one value, most significant first
  function automatic void push_decimal(input logic [63:0] value);
    logic [63:0] v;
    logic [3:0]  rev[20];
    int          n;
    digit_t      d;
    v = value;
    n = 0;
    do begin
      rev[n] = 4'(v % 64'd10);
      v = v / 64'd10;
      n++;
    end while (v != 0 && n < 20);
    for (int k = 0; k < n; k++) begin
      d.digit_char = 6'd48 + 6'(rev[n-1-k]);
      d.last = (k == n - 1);
      pending_digits.push_back(d);
    end
  endfunction

  function automatic void report_mismatch(input string what, input logic [7:0] exp_v,
                                          input logic [7:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h got %0h", what, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_unsigned_to_decimal_ascii NOT OK");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    digit_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_digits.size() == 0) begin
        report_mismatch("unexpected digit", 8'h00, out_tdata);
      end else begin
        e = pending_digits.pop_front();
        if (out_tdata !== {2'b00, e.digit_char})
          report_mismatch("digit_char", {2'b00, e.digit_char}, out_tdata);
        if (out_tlast !== e.last)
          report_mismatch("tlast", {7'd0, e.last}, {7'd0, out_tlast});
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n)
      out_tready <= 1'b0;
    else if (hold_off)
      out_tready <= 1'b0;
    else
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off so the pipeline fills and backs up
  task automatic stall_receiver(input int cycles);
    hold_off = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off = 1'b0;
  endtask

  task automatic send_value(input logic [63:0] value, input bit check_fixed,
                            input digit_t fixed_digit);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    if (check_fixed) pending_digits.push_back(fixed_digit);
    else push_decimal(value);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          sel;
    v = {$urandom(), $urandom()};
    sel = $urandom_range(3);
    // spread digit counts: short, medium and full width
    if (sel == 0) v = v >> $urandom_range(63);
    else if (sel == 1) v = v % 64'd1000;
    return v;
  endfunction

  typedef struct {
    logic [63:0] value;
    bit          fixed;
    digit_t      digit;
  } stim_row_t;

  stim_row_t directed[] = '{
    '{64'd0,                    1'b1, '{6'd48, 1'b1}},
    '{64'd1,                    1'b1, '{6'd49, 1'b1}},
    '{64'd9,                    1'b1, '{6'd57, 1'b1}},
    '{64'd10,                   1'b0, '{6'd0, 1'b0}},
    '{64'd99,                   1'b0, '{6'd0, 1'b0}},
    '{64'd100,                  1'b0, '{6'd0, 1'b0}},
    '{64'd255,                  1'b0, '{6'd0, 1'b0}},
    '{64'd1000000,              1'b0, '{6'd0, 1'b0}},
    '{64'd9999999999,           1'b0, '{6'd0, 1'b0}},
    '{64'd10000000000000000000, 1'b0, '{6'd0, 1'b0}},
    '{64'd9999999999999999999,  1'b0, '{6'd0, 1'b0}},
    '{64'hFFFFFFFFFFFFFFFF,     1'b0, '{6'd0, 1'b0}},
    '{64'h8000000000000000,     1'b0, '{6'd0, 1'b0}},
    '{64'h7FFFFFFFFFFFFFFF,     1'b0, '{6'd0, 1'b0}},
    '{64'h5555555555555555,     1'b0, '{6'd0, 1'b0}},
    '{64'hAAAAAAAAAAAAAAAA,     1'b0, '{6'd0, 1'b0}},
    '{64'd0,                    1'b1, '{6'd48, 1'b1}}
  };

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    hold_off = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_value(directed[i].value, directed[i].fixed, directed[i].digit);

    send_idle_pct = 36;
    recv_idle_pct = 54;
    for (int i = 0; i < 50; i++) send_value(random_value(), 1'b0, '{6'd0, 1'b0});

    fork
      stall_receiver(300);
      for (int i = 0; i < 10; i++) send_value(random_value(), 1'b0, '{6'd0, 1'b0});
    join

    send_idle_pct = 54;
    recv_idle_pct = 36;
    for (int i = 0; i < 45; i++) send_value(random_value(), 1'b0, '{6'd0, 1'b0});

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 45; i++) send_value(random_value(), 1'b0, '{6'd0, 1'b0});
    in_tvalid <= 1'b0;

    while (pending_digits.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("tb_unsigned_to_decimal_ascii OK");
    else
      $display("tb_unsigned_to_decimal_ascii NOT OK");
    $finish;
  end
endmodule
